>>> src/gopr_pkg.sv
// shared types and constants for the obstacle placement reachability block
package gopr_pkg;

  localparam int MAX_ROWS   = 16;
  localparam int MAX_COLS   = 16;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int CELL_W     = ROW_W + COL_W;
  localparam int CELLS      = MAX_ROWS * MAX_COLS;
  localparam int SP_W       = CELL_W + 1;
  localparam int SIZE_W     = 5;
  localparam int POS_W      = 4;
  localparam int STATUS_W   = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 5;
  localparam int NB_W       = 3;
  localparam int VIS_W      = 8;
  localparam int GRID_W     = VIS_W + 1;
  localparam logic [NB_W-1:0] NB_LAST = NB_W'(4);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_GRID_ROWS = 3'd0,
    CFG_GRID_COLS = 3'd1,
    CFG_START_ROW = 3'd2,
    CFG_START_COL = 3'd3,
    CFG_GOAL_ROW  = 3'd4,
    CFG_GOAL_COL  = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    OP_PLACE = 1'b0,
    OP_CHECK = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    RES_OK     = 2'd0,
    RES_REJECT = 2'd1,
    RES_BLOCK  = 2'd2
  } res_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PCHK,
    S_FINIT,
    S_FSEED,
    S_POP,
    S_NB,
    S_UNDO,
    S_OUT,
    S_VRD,
    S_VWR
  } fsm_t;

endpackage

>>> src/gopr_if.sv
// request and result channel interfaces
interface gopr_in_if import gopr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [POS_W-1:0] cell_row;
  logic [POS_W-1:0] cell_col;

  modport source (output valid, opcode, cell_row, cell_col, input ready);
  modport sink   (input valid, opcode, cell_row, cell_col, output ready);
endinterface

interface gopr_out_if import gopr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                path_exists;

  modport source (output valid, status, path_exists, input ready);
  modport sink   (input valid, status, path_exists, output ready);
endinterface

>>> src/grid_obstacle_place_reachability.sv
// obstacle grid with entrance-to-target reachability guard, top level
//
// in_ch carries requests (opcode, cell_row, cell_col), out_ch one result per
// request (status, path_exists); both transfer on valid and ready high.
// cfg_we/cfg_addr/cfg_wdata write the six grid registers; the user is to
// write them only while idle, as the block itself does not enforce this. one
// grid memory word per cell holds the obstacle bit and a visited epoch. a
// reachability flood reads one stack entry and then one grid word per
// neighbor through the single read port of the grid memory. every 255th
// flood (the 256th for the first one after reset) first runs a pass that
// resets the epochs. a check request takes one flood; a place request takes
// one flood when it is taken, two when it blocks the path (plus an undo
// write), and one flood after a reject. the result sits in an output
// register, so a new request is taken while it waits; a stalled receiver
// holds only the next result. after reset a clearing pass zeroes the grid
// memory and in_ch.ready stays low; configuration returns to 10 x 10 grid,
// entrance (0,0), target (9,9).
module grid_obstacle_place_reachability import gopr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  gopr_in_if.sink               in_ch,
  gopr_out_if.source            out_ch
);

  // configuration
  logic [SIZE_W-1:0] grid_rows_r, grid_cols_r;
  logic [POS_W-1:0]  start_row_r, start_col_r, goal_row_r, goal_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= SIZE_W'(10);
      grid_cols_r <= SIZE_W'(10);
      start_row_r <= POS_W'(0);
      start_col_r <= POS_W'(0);
      goal_row_r  <= POS_W'(9);
      goal_col_r  <= POS_W'(9);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_GRID_ROWS: grid_rows_r <= cfg_wdata;
        CFG_GRID_COLS: grid_cols_r <= cfg_wdata;
        CFG_START_ROW: start_row_r <= cfg_wdata[POS_W-1:0];
        CFG_START_COL: start_col_r <= cfg_wdata[POS_W-1:0];
        CFG_GOAL_ROW:  goal_row_r  <= cfg_wdata[POS_W-1:0];
        CFG_GOAL_COL:  goal_col_r  <= cfg_wdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SIZE_W-1:0] rows_used, cols_used;
  assign rows_used = (grid_rows_r > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : grid_rows_r;
  assign cols_used = (grid_cols_r > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : grid_cols_r;

  // memories, grid word is {visited epoch, obstacle}
  logic [GRID_W-1:0] grid_mem [CELLS];
  logic [CELL_W-1:0] stk_mem [CELLS];
  logic              grid_we;
  logic [GRID_W-1:0] grid_wdata, grid_q;
  logic [CELL_W-1:0] grid_waddr, grid_raddr;
  logic              stk_we;
  logic [CELL_W-1:0] stk_waddr, stk_wdata, stk_raddr, stk_q;

  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_mem[grid_waddr] <= grid_wdata;
    end
    grid_q <= grid_mem[grid_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_q <= stk_mem[stk_raddr];
  end

  // control and datapath registers
  fsm_t              state_r, state_nxt;
  logic [CELL_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [VIS_W-1:0]  epoch_r, epoch_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [NB_W-1:0]   nb_r, nb_nxt;
  logic [CELL_W-1:0] cur_r, cur_nxt;
  logic              cand_ok_r, cand_ok_nxt;
  logic [CELL_W-1:0] cand_idx_r, cand_idx_nxt;
  logic [POS_W-1:0]  row_r, row_nxt, col_r, col_nxt;
  logic              probe_r, probe_nxt;
  res_t              pend_status_r, pend_status_nxt;
  logic              pend_path_r, pend_path_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              status_r, status_nxt;
  logic              path_r, path_nxt;

  // neighbor generation
  logic [CELL_W-1:0] cur_sel, nb_idx, in_idx, start_idx, goal_idx, place_idx;
  logic [POS_W:0]    nr, nc;
  logic              dir_ok, nb_ok, start_ok, push_ok, obs_q, seen_q;

  assign cur_sel   = (nb_r == NB_W'(0)) ? stk_q : cur_r;
  assign in_idx    = {in_ch.cell_row, in_ch.cell_col};
  assign start_idx = {start_row_r, start_col_r};
  assign goal_idx  = {goal_row_r, goal_col_r};
  assign place_idx = {row_r, col_r};
  assign obs_q     = grid_q[0];
  assign seen_q    = (grid_q[GRID_W-1:1] == epoch_r);

  always_comb begin
    nr     = {1'b0, cur_sel[CELL_W-1:COL_W]};
    nc     = {1'b0, cur_sel[COL_W-1:0]};
    dir_ok = 1'b1;
    case (nb_r[1:0])
      2'd0: nr = nr + (POS_W+1)'(1);
      2'd1: begin
        dir_ok = (nr != '0);
        nr     = nr - (POS_W+1)'(1);
      end
      2'd2: nc = nc + (POS_W+1)'(1);
      2'd3: begin
        dir_ok = (nc != '0);
        nc     = nc - (POS_W+1)'(1);
      end
      default: ;
    endcase
  end

  assign nb_ok    = dir_ok && (nr < rows_used) && (nc < cols_used);
  assign nb_idx   = {nr[POS_W-1:0], nc[POS_W-1:0]};
  assign start_ok = ({1'b0, start_row_r} < rows_used) && ({1'b0, start_col_r} < cols_used);
  assign push_ok  = cand_ok_r && !seen_q && !obs_q && (sp_r < SP_W'(CELLS));

  logic in_xfer, out_load, place_reject, flood_end, flood_found;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_load     = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);
  assign place_reject = !(({1'b0, row_r} < rows_used) && ({1'b0, col_r} < cols_used)) ||
                        obs_q || (place_idx == start_idx) || (place_idx == goal_idx);
  assign flood_found  = (state_r == S_NB) && (nb_r == NB_W'(0)) && (stk_q == goal_idx);
  assign flood_end    = flood_found || ((state_r == S_POP) && (sp_r == '0));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_cnt_r == CELL_W'(CELLS - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = (op_t'(in_ch.opcode) == OP_CHECK) ? S_FINIT : S_PCHK;
        end
      end
      S_PCHK:  state_nxt = S_FINIT;
      S_FINIT: state_nxt = (epoch_r == '1) ? S_VRD : S_FSEED;
      S_VRD:   state_nxt = S_VWR;
      S_VWR: begin
        if (clr_cnt_r == CELL_W'(CELLS - 1)) begin
          state_nxt = S_FINIT;
        end else begin
          state_nxt = S_VRD;
        end
      end
      S_FSEED: state_nxt = S_POP;
      S_POP: begin
        if (flood_end) begin
          state_nxt = probe_r ? S_UNDO : S_OUT;
        end else begin
          state_nxt = S_NB;
        end
      end
      S_NB: begin
        if (flood_found) begin
          state_nxt = S_OUT;
        end else if (nb_r == NB_LAST) begin
          state_nxt = S_POP;
        end
      end
      S_UNDO:  state_nxt = S_FINIT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    clr_cnt_nxt     = clr_cnt_r;
    epoch_nxt       = epoch_r;
    sp_nxt          = sp_r;
    nb_nxt          = nb_r;
    cur_nxt         = cur_r;
    cand_ok_nxt     = cand_ok_r;
    cand_idx_nxt    = cand_idx_r;
    row_nxt         = row_r;
    col_nxt         = col_r;
    probe_nxt       = probe_r;
    pend_status_nxt = pend_status_r;
    pend_path_nxt   = pend_path_r;
    status_nxt      = status_r;
    path_nxt        = path_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    grid_we         = 1'b0;
    grid_waddr      = place_idx;
    grid_wdata      = '0;
    grid_raddr      = nb_idx;
    stk_we          = 1'b0;
    stk_waddr       = sp_r[CELL_W-1:0];
    stk_wdata       = cand_idx_r;
    stk_raddr       = sp_r[CELL_W-1:0] - CELL_W'(1);

    case (state_r)
      S_CLEAR: begin
        grid_we     = 1'b1;
        grid_waddr  = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + CELL_W'(1);
      end
      S_IDLE: begin
        grid_raddr = in_idx;
        if (in_xfer) begin
          row_nxt         = in_ch.cell_row;
          col_nxt         = in_ch.cell_col;
          probe_nxt       = 1'b0;
          pend_status_nxt = RES_OK;
        end
      end
      S_PCHK: begin
        if (place_reject) begin
          pend_status_nxt = RES_REJECT;
        end else begin
          grid_we    = 1'b1;
          grid_wdata = {VIS_W'(0), 1'b1};
          probe_nxt  = 1'b1;
        end
      end
      S_FINIT: begin
        grid_raddr   = start_idx;
        sp_nxt       = '0;
        cand_ok_nxt  = start_ok;
        cand_idx_nxt = start_idx;
        if (epoch_r != '1) begin
          epoch_nxt = epoch_r + VIS_W'(1);
        end
      end
      S_VRD: begin
        grid_raddr = clr_cnt_r;
      end
      S_VWR: begin
        grid_we     = 1'b1;
        grid_waddr  = clr_cnt_r;
        grid_wdata  = {VIS_W'(0), obs_q};
        clr_cnt_nxt = clr_cnt_r + CELL_W'(1);
        if (clr_cnt_r == CELL_W'(CELLS - 1)) begin
          epoch_nxt = '0;
        end
      end
      S_FSEED: begin
        if (push_ok) begin
          stk_we     = 1'b1;
          sp_nxt     = sp_r + SP_W'(1);
          grid_we    = 1'b1;
          grid_waddr = cand_idx_r;
          grid_wdata = {epoch_r, 1'b0};
        end
      end
      S_POP: begin
        nb_nxt = '0;
        if (flood_end) begin
          pend_path_nxt = 1'b0;
          if (probe_r) begin
            pend_status_nxt = RES_BLOCK;
          end
        end else begin
          sp_nxt = sp_r - SP_W'(1);
        end
      end
      S_NB: begin
        nb_nxt  = nb_r + NB_W'(1);
        cur_nxt = cur_sel;
        if (flood_found) begin
          pend_path_nxt = 1'b1;
          probe_nxt     = 1'b0;
        end else begin
          if (nb_r != NB_LAST) begin
            cand_ok_nxt  = nb_ok;
            cand_idx_nxt = nb_idx;
          end
          if (nb_r != NB_W'(0) && push_ok) begin
            stk_we     = 1'b1;
            sp_nxt     = sp_r + SP_W'(1);
            grid_we    = 1'b1;
            grid_waddr = cand_idx_r;
            grid_wdata = {epoch_r, 1'b0};
          end
        end
      end
      S_UNDO: begin
        grid_we    = 1'b1;
        grid_wdata = '0;
        probe_nxt  = 1'b0;
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          status_nxt    = pend_status_r;
          path_nxt      = pend_path_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      epoch_r     <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
      probe_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      epoch_r     <= epoch_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
      probe_r     <= probe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nb_r          <= nb_nxt;
    cur_r         <= cur_nxt;
    cand_ok_r     <= cand_ok_nxt;
    cand_idx_r    <= cand_idx_nxt;
    row_r         <= row_nxt;
    col_r         <= col_nxt;
    pend_status_r <= pend_status_nxt;
    pend_path_r   <= pend_path_nxt;
    status_r      <= status_nxt;
    path_r        <= path_nxt;
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.path_exists = path_r;

endmodule

>>> src/gopr_checker.sv
// port-level checks for the obstacle placement block and their bind
module gopr_checker import gopr_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic                out_path_exists
);

  // no request taken and no result shown right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("request or result active after reset");

  // a request keeps the block busy for at least the following cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a request transfer");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == RES_OK) || (out_status == RES_REJECT) ||
                  (out_status == RES_BLOCK))
    else $error("result with unknown status code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_path_exists))
    else $error("stalled result changed");

endmodule

bind grid_obstacle_place_reachability gopr_checker u_gopr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_path_exists (out_ch.path_exists)
);

>>> bench/grid_obstacle_place_reachability_tb.sv
// self-checking bench for the obstacle placement reachability block
`timescale 1ns / 100ps

module grid_obstacle_place_reachability_tb;
  import gopr_pkg::*;

  localparam int CYCLE_LIMIT = 12_000_000;
  localparam int DRAIN_WAIT  = 3200;
  localparam int LONG_HOLD   = 8000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 72;

  typedef struct packed {
    res_t status;
    logic path;
  } verdict_t;

  typedef struct {
    bit                    is_reg;
    cfg_idx_t              reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    op_t                   op;
    logic [POS_W-1:0]      row;
    logic [POS_W-1:0]      col;
    bit                    typed;
    verdict_t              want;
  } step_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  cfg_idx_t              cfg_addr;

  gopr_in_if  in_if ();
  gopr_out_if out_if ();

  grid_obstacle_place_reachability i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  // predictor state
  bit [CELLS-1:0] obstacles;
  bit [CELLS-1:0] flood_seen;
  int             flood_stack[$];
  int             rows_reg, cols_reg, entr_row, entr_col, tgt_row, tgt_col;

  step_t    plan[$];
  verdict_t awaited_verdicts[$];
  verdict_t oldest;
  int       mismatches;
  int       cycles;
  int       holds_wanted, holds_served, hold_left;
  int       ready_mode, mode_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void plan_add(input step_t s);
    plan.insert(plan.size(), s);
  endfunction

  function automatic int rows_in_use();
    return rows_reg > MAX_ROWS ? MAX_ROWS : rows_reg;
  endfunction

  function automatic int cols_in_use();
    return cols_reg > MAX_COLS ? MAX_COLS : cols_reg;
  endfunction

  function automatic void flood_push(input int r, input int c);
    int idx;
    if (r >= rows_in_use() || c >= cols_in_use()) return;
    idx = r * MAX_COLS + c;
    if (flood_seen[idx] || obstacles[idx]) return;
    flood_seen[idx] = 1'b1;
    flood_stack.insert(flood_stack.size(), idx);
  endfunction

  function automatic bit target_reachable();
    int idx, r, c;
    flood_seen = '0;
    flood_stack.delete();
    flood_push(entr_row, entr_col);
    while (flood_stack.size() != 0) begin
      idx = flood_stack.pop_back();
      r = idx / MAX_COLS;
      c = idx % MAX_COLS;
      if (r == tgt_row && c == tgt_col) return 1'b1;
      flood_push(r + 1, c);
      if (r > 0) flood_push(r - 1, c);
      flood_push(r, c + 1);
      if (c > 0) flood_push(r, c - 1);
    end
    return 1'b0;
  endfunction

  function automatic void judge_request(input op_t op, input int r, input int c,
                                        output res_t st, output logic pe);
    int idx;
    idx = r * MAX_COLS + c;
    st = RES_OK;
    if (op == OP_PLACE) begin
      if (r >= rows_in_use() || c >= cols_in_use() || obstacles[idx] ||
          (r == entr_row && c == entr_col) || (r == tgt_row && c == tgt_col)) begin
        st = RES_REJECT;
      end else begin
        obstacles[idx] = 1'b1;
        if (!target_reachable()) begin
          obstacles[idx] = 1'b0;
          st = RES_BLOCK;
        end
      end
    end
    pe = target_reachable();
  endfunction

  function automatic step_t req(input op_t op, input int r, input int c,
                                input bit typed = 1'b0, input res_t st = RES_OK,
                                input logic pe = 1'b0);
    step_t s;
    s.is_reg      = 1'b0;
    s.reg_idx     = CFG_GRID_ROWS;
    s.reg_val     = '0;
    s.op          = op;
    s.row         = r[POS_W-1:0];
    s.col         = c[POS_W-1:0];
    s.typed       = typed;
    s.want.status = st;
    s.want.path   = pe;
    return s;
  endfunction

  function automatic step_t reg_wr(input cfg_idx_t idx, input int val);
    step_t s;
    s = req(OP_CHECK, 0, 0);
    s.is_reg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val[CFG_DATA_W-1:0];
    return s;
  endfunction

  task automatic set_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_GRID_ROWS: rows_reg = val;
      CFG_GRID_COLS: cols_reg = val;
      CFG_START_ROW: entr_row = val[POS_W-1:0];
      CFG_START_COL: entr_col = val[POS_W-1:0];
      CFG_GOAL_ROW:  tgt_row  = val[POS_W-1:0];
      CFG_GOAL_COL:  tgt_col  = val[POS_W-1:0];
      default: ;
    endcase
  endtask

  // leaves valid high, the caller drives the next item or drops valid at once
  task automatic put_request(input step_t s);
    verdict_t v;
    if (cfg_we) cfg_we <= 1'b0;
    in_if.valid    <= 1'b1;
    in_if.opcode   <= s.op;
    in_if.cell_row <= s.row;
    in_if.cell_col <= s.col;
    do @(posedge clk); while (!in_if.ready);
    judge_request(s.op, s.row, s.col, v.status, v.path);
    awaited_verdicts.insert(awaited_verdicts.size(), s.typed ? s.want : v);
  endtask

  task automatic settle();
    if (in_if.valid) in_if.valid <= 1'b0;
    if (cfg_we) cfg_we <= 1'b0;
    while (awaited_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (holds_served != holds_wanted) begin
      holds_served <= holds_served + 1;
      hold_left    <= LONG_HOLD;
      out_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(20, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 1) == 1);
        default: out_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (awaited_verdicts.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: status %0d path %0b", out_if.status,
                   out_if.path_exists);
        mismatches <= mismatches + 1;
      end else begin
        oldest = awaited_verdicts.pop_front();
        if (out_if.status !== oldest.status || out_if.path_exists !== oldest.path) begin
          if (mismatches < 10)
            $display("mismatch: expected status %0d path %0b, got status %0d path %0b",
                     oldest.status, oldest.path, out_if.status, out_if.path_exists);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    bit    prev_reg;
    int    p, k, b, burst, gap, kind, eff_r, eff_c;
    int    n_rows, n_cols, s_row, s_col, g_row, g_col;

    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_addr       <= CFG_GRID_ROWS;
    cfg_wdata      <= '0;
    in_if.valid    <= 1'b0;
    in_if.opcode   <= OP_PLACE;
    in_if.cell_row <= '0;
    in_if.cell_col <= '0;
    mismatches = 0;
    cycles = 0;
    holds_wanted = 0;
    holds_served = 0;
    hold_left = 0;
    ready_mode = 0;
    mode_left = 0;
    obstacles = '0;
    rows_reg = 10;
    cols_reg = 10;
    entr_row = 0;
    entr_col = 0;
    tgt_row = 9;
    tgt_col = 9;

    // reset grid 10 x 10, entrance (0,0), target (9,9)
    plan_add(req(OP_CHECK, 0, 0, 1'b1, RES_OK, 1'b1));
    plan_add(req(OP_PLACE, 0, 0, 1'b1, RES_REJECT, 1'b1));
    plan_add(req(OP_PLACE, 9, 9, 1'b1, RES_REJECT, 1'b1));
    plan_add(req(OP_PLACE, 10, 3, 1'b1, RES_REJECT, 1'b1));
    plan_add(req(OP_PLACE, 3, 15, 1'b1, RES_REJECT, 1'b1));
    plan_add(req(OP_PLACE, 15, 15, 1'b1, RES_REJECT, 1'b1));
    plan_add(req(OP_PLACE, 0, 1, 1'b1, RES_OK, 1'b1));
    plan_add(req(OP_PLACE, 0, 1, 1'b1, RES_REJECT, 1'b1));
    plan_add(req(OP_PLACE, 1, 0, 1'b1, RES_BLOCK, 1'b1));
    plan_add(req(OP_PLACE, 1, 1));
    // entrance moved onto an obstacle
    plan_add(reg_wr(CFG_START_ROW, 1));
    plan_add(reg_wr(CFG_START_COL, 1));
    plan_add(req(OP_CHECK, 7, 2, 1'b1, RES_OK, 1'b0));
    plan_add(req(OP_PLACE, 5, 5, 1'b1, RES_BLOCK, 1'b0));
    // entrance equal to target
    plan_add(reg_wr(CFG_START_ROW, 0));
    plan_add(reg_wr(CFG_START_COL, 0));
    plan_add(reg_wr(CFG_GOAL_ROW, 0));
    plan_add(reg_wr(CFG_GOAL_COL, 0));
    plan_add(req(OP_CHECK, 0, 0, 1'b1, RES_OK, 1'b1));
    // oversized grid clamps to the full array
    plan_add(reg_wr(CFG_GRID_ROWS, 31));
    plan_add(reg_wr(CFG_GRID_COLS, 31));
    plan_add(reg_wr(CFG_GOAL_ROW, 15));
    plan_add(reg_wr(CFG_GOAL_COL, 15));
    plan_add(req(OP_CHECK, 15, 0));
    plan_add(req(OP_PLACE, 15, 15));
    plan_add(req(OP_PLACE, 12, 7));
    // zero rows, nothing in bounds
    plan_add(reg_wr(CFG_GRID_ROWS, 0));
    plan_add(req(OP_PLACE, 0, 5, 1'b1, RES_REJECT, 1'b0));
    plan_add(req(OP_CHECK, 0, 0, 1'b1, RES_OK, 1'b0));
    // single row, target outside the area
    plan_add(reg_wr(CFG_GRID_ROWS, 1));
    plan_add(reg_wr(CFG_GRID_COLS, 16));
    plan_add(req(OP_PLACE, 0, 5, 1'b1, RES_BLOCK, 1'b0));
    plan_add(reg_wr(CFG_GOAL_ROW, 0));
    plan_add(reg_wr(CFG_GOAL_COL, 15));
    plan_add(req(OP_CHECK, 0, 0, 1'b1, RES_OK, 1'b0));
    plan_add(req(OP_PLACE, 0, 1, 1'b1, RES_REJECT, 1'b0));
    // grow back, stored obstacles return
    plan_add(reg_wr(CFG_GRID_ROWS, 10));
    plan_add(reg_wr(CFG_GRID_COLS, 10));
    plan_add(reg_wr(CFG_GOAL_ROW, 9));
    plan_add(reg_wr(CFG_GOAL_COL, 9));
    plan_add(req(OP_CHECK, 3, 3));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    prev_reg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (!prev_reg) settle();
        set_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        put_request(plan[i]);
      end
      prev_reg = plan[i].is_reg;
    end

    for (p = 0; p < PHASES; p++) begin
      settle();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: n_rows = $urandom_range(2, 10);
        7:                   n_rows = 16;
        8:                   n_rows = 31;
        default:             n_rows = $urandom_range(1, 3);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: n_cols = $urandom_range(2, 10);
        7:                   n_cols = 16;
        8:                   n_cols = 31;
        default:             n_cols = $urandom_range(1, 3);
      endcase
      if (p == 4) begin
        n_rows = 16;
        n_cols = 16;
      end
      eff_r = n_rows > MAX_ROWS ? MAX_ROWS : n_rows;
      eff_c = n_cols > MAX_COLS ? MAX_COLS : n_cols;
      s_row = $urandom_range(0, eff_r - 1);
      s_col = $urandom_range(0, eff_c - 1);
      g_row = $urandom_range(0, eff_r - 1);
      g_col = $urandom_range(0, eff_c - 1);
      if ($urandom_range(0, 7) == 0) begin
        s_row = $urandom_range(0, 15);
        g_col = $urandom_range(0, 15);
      end
      set_reg(CFG_GRID_ROWS, CFG_DATA_W'(n_rows));
      set_reg(CFG_GRID_COLS, CFG_DATA_W'(n_cols));
      set_reg(CFG_START_ROW, CFG_DATA_W'(s_row));
      set_reg(CFG_START_COL, CFG_DATA_W'(s_col));
      set_reg(CFG_GOAL_ROW, CFG_DATA_W'(g_row));
      set_reg(CFG_GOAL_COL, CFG_DATA_W'(g_col));
      // long receiver hold-off while requests keep coming
      if (p == 2 || p == 7) holds_wanted = holds_wanted + 1;

      k = 0;
      while (k < PHASE_ITEMS) begin
        burst = $urandom_range(1, 12);
        for (b = 0; b < burst && k < PHASE_ITEMS; b++) begin
          kind = $urandom_range(0, 9);
          if (kind == 0)
            put_request(req(OP_CHECK, $urandom_range(0, 15), $urandom_range(0, 15)));
          else if (kind == 1)
            put_request(req(OP_PLACE, $urandom_range(0, 15), $urandom_range(0, 15)));
          else
            put_request(req(OP_PLACE, $urandom_range(0, eff_r - 1),
                            $urandom_range(0, eff_c - 1)));
          k++;
          if (p == 6 && k == PHASE_ITEMS / 2) settle();
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        if (gap != 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    settle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && awaited_verdicts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
